// ----- design/mm_pkg.sv -----
// ----------------------------------------------------------------------------
// mm_pkg
// Shared constants, codes and types of the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  // dimension limit default, handed to the top level parameter
  localparam int MAX_DIM_DEF = 8;

  // field and storage widths
  localparam int DIM_W       = 4;
  localparam int OP_W        = 2;
  localparam int IDX_W       = 6;
  localparam int STORE_DEPTH = 1 << IDX_W;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = 35;
  localparam int POS_W       = 3;
  localparam int CFG_IDX_W   = 2;

  // opcodes of an input beat
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  // control travelling with a read pair into the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // zero counts as one, anything above the limit counts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > max_dim) r = max_dim;
    return r;
  endfunction

endpackage

// ----- design/mm_in_if.sv -----
// ----------------------------------------------------------------------------
// mm_in_if
// Input channel: load and compute beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm_in_if import mm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         elem_index;
  logic signed [ELEM_W-1:0] elem_value;

  modport source (output valid, output op, output elem_index, output elem_value,
                  input ready);
  modport sink   (input valid, input op, input elem_index, input elem_value,
                  output ready);
endinterface

// ----- design/mm_out_if.sv -----
// ----------------------------------------------------------------------------
// mm_out_if
// Result channel: one product element per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm_out_if import mm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] product_value;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    last_flag;

  modport source (output valid, output product_value, output out_row, output out_col,
                  output last_flag, input ready);
  modport sink   (input valid, input product_value, input out_row, input out_col,
                  input last_flag, output ready);
endinterface

// ----- design/matrix_multiply_top.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_top
// Fixed-point dense matrix multiplier over two on-chip element stores.
// ----------------------------------------------------------------------------
// A load beat (op 0 or 1) writes one Q4.11 element into the A or B store. A
// compute beat (op 2) streams A*B in row-major order, one exact Q12.22
// element per output beat, the final one flagged. For each product element
// the sequencer issues one read of each store per inner term, then the read,
// multiply and accumulate stages drain and the element is handed to the
// output register; elements are computed one at a time by the single
// multiply-accumulate unit through the one read port of each store. No beat
// is accepted during a compute, and output back-pressure stalls the sequencer
// at each element.
// Dimension registers are sampled when the compute beat is accepted.
// ----------------------------------------------------------------------------
module matrix_multiply_top import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  mm_in_if.sink                in_s,
  mm_out_if.source             out_s
);

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // configuration registers
  logic [DIM_W-1:0] rows_a_r, cols_a_r, cols_b_r;

  // sequencer
  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] nr_r, nk_r, nc_r, nr_nxt, nk_nxt, nc_nxt;
  logic [POS_W-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [IDX_W-1:0] a_base_r, a_addr_r, b_addr_r;
  logic [IDX_W-1:0] a_base_nxt, a_addr_nxt, b_addr_nxt;

  // stores and read stage
  logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
  logic [ELEM_W-1:0] b_mem [STORE_DEPTH];
  logic [ELEM_W-1:0] a_q_r, b_q_r;
  mac_ctl_t          issue_ctl, rd_ctl_r;

  // multiply-accumulate result
  logic                    mac_done;
  logic signed [SUM_W-1:0] mac_sum;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_val_r;
  logic [POS_W-1:0]        out_row_r, out_col_r;
  logic                    out_last_r;

  logic in_beat, slot_free, out_load, k_last, j_last, i_last;

  assign in_beat   = in_s.valid & in_s.ready;
  assign slot_free = ~out_valid_r | out_s.ready;
  assign k_last    = ({1'b0, k_r} == (nk_r - DIM_W'(1)));
  assign j_last    = ({1'b0, j_r} == (nc_r - DIM_W'(1)));
  assign i_last    = ({1'b0, i_r} == (nr_r - DIM_W'(1)));
  assign out_load  = (state_r == ST_EMIT) & slot_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A: rows_a_r <= cfg_wdata;
        CFG_COLS_A: cols_a_r <= cfg_wdata;
        CFG_COLS_B: cols_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // element stores: loads only while idle, so reads never meet a write
  always_ff @(posedge clk) begin
    if (in_beat && in_s.op == OP_LOAD_A) a_mem[in_s.elem_index] <= in_s.elem_value;
    if (in_beat && in_s.op == OP_LOAD_B) b_mem[in_s.elem_index] <= in_s.elem_value;
    a_q_r <= a_mem[a_addr_r];
    b_q_r <= b_mem[b_addr_r];
  end

  // control of the read in flight
  assign issue_ctl.valid = (state_r == ST_ISSUE);
  assign issue_ctl.first = (k_r == '0);
  assign issue_ctl.last  = k_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ctl_r <= '0;
    end else begin
      rd_ctl_r <= issue_ctl;
    end
  end

  mm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rd_ctl_r),
    .a_q   (a_q_r),
    .b_q   (b_q_r),
    .done  (mac_done),
    .sum   (mac_sum)
  );

  // sequencer next state: walk i, j, k with running store addresses
  always_comb begin
    state_nxt  = state_r;
    nr_nxt     = nr_r;
    nk_nxt     = nk_r;
    nc_nxt     = nc_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    a_base_nxt = a_base_r;
    a_addr_nxt = a_addr_r;
    b_addr_nxt = b_addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && in_s.op == OP_COMPUTE) begin
          nr_nxt     = clamp_dim(rows_a_r, MAX_DIM_V);
          nk_nxt     = clamp_dim(cols_a_r, MAX_DIM_V);
          nc_nxt     = clamp_dim(cols_b_r, MAX_DIM_V);
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          a_base_nxt = '0;
          a_addr_nxt = '0;
          b_addr_nxt = '0;
          state_nxt  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_nxt      = k_r + POS_W'(1);
        a_addr_nxt = a_addr_r + IDX_W'(1);
        b_addr_nxt = b_addr_r + IDX_W'(nc_r);
        if (k_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          k_nxt = '0;
          if (i_last && j_last) begin
            state_nxt = ST_IDLE;
          end else if (j_last) begin
            i_nxt      = i_r + POS_W'(1);
            j_nxt      = '0;
            a_base_nxt = a_base_r + IDX_W'(nk_r);
            a_addr_nxt = a_base_r + IDX_W'(nk_r);
            b_addr_nxt = '0;
            state_nxt  = ST_ISSUE;
          end else begin
            j_nxt      = j_r + POS_W'(1);
            a_addr_nxt = a_base_r;
            b_addr_nxt = IDX_W'(j_r) + IDX_W'(1);
            state_nxt  = ST_ISSUE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    nr_r     <= nr_nxt;
    nk_r     <= nk_nxt;
    nc_r     <= nc_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    a_base_r <= a_base_nxt;
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_s.ready;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= mac_sum;
      out_row_r  <= i_r;
      out_col_r  <= j_r;
      out_last_r <= i_last & j_last;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_s.ready          = (state_r == ST_IDLE);
  assign out_s.valid         = out_valid_r;
  assign out_s.product_value = out_val_r;
  assign out_s.out_row       = out_row_r;
  assign out_s.out_col       = out_col_r;
  assign out_s.last_flag     = out_last_r;

endmodule

// ----- design/mm_mac.sv -----
// ----------------------------------------------------------------------------
// mm_mac
// Multiply-accumulate unit: registered 16x16 signed product, then an exact
// 35-bit accumulator that restarts on the first term of each element.
// ----------------------------------------------------------------------------
module mm_mac import mm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [ELEM_W-1:0] a_q,
  input  logic signed [ELEM_W-1:0] b_q,
  output logic                     done,
  output logic signed [SUM_W-1:0]  sum
);

  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 prod_ctl_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_nxt;
  logic                     done_r;

  // product stage
  always_ff @(posedge clk) begin
    prod_r <= a_q * b_q;
    if (!rst_n) begin
      prod_ctl_r <= '0;
    end else begin
      prod_ctl_r <= ctl;
    end
  end

  // accumulate, restarting on the first term
  always_comb begin
    acc_nxt = (prod_ctl_r.first ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (prod_ctl_r.valid) acc_r <= acc_nxt;
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= prod_ctl_r.valid & prod_ctl_r.last;
    end
  end

  assign done = done_r;
  assign sum  = acc_r;

endmodule

// ----- design/mm_checker.sv -----
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks of the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm_checker import mm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [OP_W-1:0]         in_op,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] out_value,
  input logic                    out_last
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result beat changed");

  // a compute beat makes the block busy on the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_COMPUTE |=> !in_ready)
    else $error("input accepted right after a compute beat");

  // a load beat leaves the block ready for the next beat
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_LOAD_A || in_op == OP_LOAD_B) |=> in_ready)
    else $error("load beat did not complete in one cycle");

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_op     (in_s.op),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_value (out_s.product_value),
  .out_last  (out_s.last_flag)
);
